### hdl/ced_pkg.sv
// Shared types, character codes and packing helper for the C literal escape decoder.
// Used by ced_front, ced_queue, ced_back and c_literal_escape_decoder_core.
package ced_pkg;

  localparam int VALUE_BITS  = 64;   // width of the packed character-constant value
  localparam int QDEPTH      = 4;    // entries in the front-to-back queue
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);
  localparam int OCT_W       = 9;
  localparam int OCT_DIGITS  = 3;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_SEVEN  = 8'h37;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] OCT_MASK  = 8'hFF;

  localparam logic MODE_OPEN = 1'b0;
  localparam logic MODE_CHAR = 1'b1;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_END  = 1'b1;

  typedef struct packed {
    logic       mode;
    logic [7:0] symbol;
  } in_word_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic [63:0] char_value;
    logic        is_char_const;
    logic        newline_error;
    logic        last;
  } out_word_t;

  // one queue entry holds every result of one input word
  typedef struct packed {
    logic      two;
    out_word_t r0;
    out_word_t r1;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] pv;
    logic                  stopped;
  } pack_t;

  function automatic pack_t pack_byte(input pack_t cur, input logic is_char,
                                      input logic [7:0] b);
    pack_t r;
    r = cur;
    if (is_char && !cur.stopped) begin
      if (b == CH_NUL) begin
        r.stopped = 1'b1;
      end else begin
        r.pv = (cur.pv << 8) | VALUE_BITS'(b);
      end
    end
    return r;
  endfunction

  function automatic logic is_octal(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_SEVEN);
  endfunction

  function automatic logic [7:0] map_escape(input logic [7:0] c);
    logic [7:0] r;
    case (c)
      CH_N:    r = CH_LF;
      CH_T:    r = CH_TAB;
      CH_B:    r = CH_BS;
      CH_R:    r = CH_CR;
      CH_F:    r = CH_FF;
      default: r = c;
    endcase
    return r;
  endfunction

endpackage

### hdl/ced_front.sv
// Front end: holds the literal state, classifies each character word and
// builds the queue entry with its results. Depends on ced_pkg.
module ced_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              acc,
  input  ced_pkg::in_word_t in_word,
  output logic              push,
  output ced_pkg::entry_t   push_entry
);

  logic                            open_r, open_nxt;
  logic [7:0]                      delim_r, delim_nxt;
  logic                            esc_r, esc_nxt;
  logic                            oct_r, oct_nxt;
  logic [ced_pkg::OCT_W-1:0]       oacc_r, oacc_nxt;
  logic [1:0]                      odig_r, odig_nxt;
  ced_pkg::pack_t                  pk_r, pk_nxt;

  logic                            isq;
  logic [7:0]                      c;
  logic                            a_emit;
  logic [7:0]                      a_byte;
  logic                            do_plain;
  logic                            b_end, b_nl, b_emit;
  ced_pkg::pack_t                  pk_a, pk_b;
  ced_pkg::out_word_t              res_a, res_b;

  always_comb begin
    c        = in_word.symbol;
    isq      = (delim_r == ced_pkg::CH_SQUOTE);
    open_nxt = open_r;
    delim_nxt = delim_r;
    esc_nxt  = esc_r;
    oct_nxt  = oct_r;
    oacc_nxt = oacc_r;
    odig_nxt = odig_r;
    a_emit   = 1'b0;
    a_byte   = '0;
    do_plain = 1'b0;

    if (in_word.mode == ced_pkg::MODE_CHAR && open_r) begin
      if (oct_r) begin
        if (ced_pkg::is_octal(c) && odig_r < 2'(ced_pkg::OCT_DIGITS)) begin
          oacc_nxt = (oacc_r << 3) + ced_pkg::OCT_W'(c - ced_pkg::CH_ZERO);
          odig_nxt = odig_r + 2'd1;
          if (odig_nxt == 2'(ced_pkg::OCT_DIGITS)) begin
            a_emit   = 1'b1;
            a_byte   = oacc_nxt[7:0] & ced_pkg::OCT_MASK;
            oct_nxt  = 1'b0;
            oacc_nxt = '0;
            odig_nxt = '0;
          end
        end else begin
          // run cut short: flush the byte, then treat c as unescaped
          a_emit   = 1'b1;
          a_byte   = oacc_r[7:0] & ced_pkg::OCT_MASK;
          oct_nxt  = 1'b0;
          oacc_nxt = '0;
          odig_nxt = '0;
          do_plain = 1'b1;
        end
      end else if (esc_r) begin
        esc_nxt = 1'b0;
        if (ced_pkg::is_octal(c)) begin
          oct_nxt  = 1'b1;
          oacc_nxt = ced_pkg::OCT_W'(c - ced_pkg::CH_ZERO);
          odig_nxt = 2'd1;
        end else begin
          a_emit = 1'b1;
          a_byte = ced_pkg::map_escape(c);
        end
      end else begin
        do_plain = 1'b1;
      end
    end

    // unescaped character: delimiter test comes first
    b_end  = do_plain && ((c == delim_r) || (c == ced_pkg::CH_LF));
    b_nl   = do_plain && (c != delim_r) && (c == ced_pkg::CH_LF);
    b_emit = do_plain && !b_end && (c != ced_pkg::CH_BSLASH);
    if (do_plain && !b_end && c == ced_pkg::CH_BSLASH) begin
      esc_nxt = 1'b1;
    end

    pk_a = a_emit ? ced_pkg::pack_byte(pk_r, isq, a_byte) : pk_r;
    pk_b = b_emit ? ced_pkg::pack_byte(pk_a, isq, c) : pk_a;
    pk_nxt = pk_b;

    if (b_end) begin
      open_nxt = 1'b0;
      esc_nxt  = 1'b0;
      oct_nxt  = 1'b0;
      oacc_nxt = '0;
      odig_nxt = '0;
      pk_nxt   = '0;
    end

    if (in_word.mode == ced_pkg::MODE_OPEN) begin
      open_nxt  = 1'b1;
      delim_nxt = c;
      esc_nxt   = 1'b0;
      oct_nxt   = 1'b0;
      oacc_nxt  = '0;
      odig_nxt  = '0;
      pk_nxt    = '0;
    end

    res_a.kind          = ced_pkg::KIND_BYTE;
    res_a.data_byte     = a_byte;
    res_a.char_value    = '0;
    res_a.is_char_const = isq;
    res_a.newline_error = 1'b0;
    res_a.last          = !(b_end || b_emit);

    res_b.kind          = b_end ? ced_pkg::KIND_END : ced_pkg::KIND_BYTE;
    res_b.data_byte     = b_end ? 8'h00 : c;
    res_b.char_value    = (b_end && isq) ? 64'(pk_a.pv) : 64'h0;
    res_b.is_char_const = isq;
    res_b.newline_error = b_nl;
    res_b.last          = 1'b1;

    push_entry.two = a_emit && (b_end || b_emit);
    push_entry.r0  = a_emit ? res_a : res_b;
    push_entry.r1  = res_b;
    push           = acc && (a_emit || b_end || b_emit);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r  <= 1'b0;
      delim_r <= '0;
      esc_r   <= 1'b0;
      oct_r   <= 1'b0;
      oacc_r  <= '0;
      odig_r  <= '0;
      pk_r    <= '0;
    end else if (acc) begin
      open_r  <= open_nxt;
      delim_r <= delim_nxt;
      esc_r   <= esc_nxt;
      oct_r   <= oct_nxt;
      oacc_r  <= oacc_nxt;
      odig_r  <= odig_nxt;
      pk_r    <= pk_nxt;
    end
  end

endmodule

### hdl/ced_queue.sv
// Short FIFO of result entries between the front and back ends.
// Depends on ced_pkg.
module ced_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  ced_pkg::entry_t     push_entry,
  input  logic                pop,
  output ced_pkg::entry_t     head,
  output ced_pkg::q_status_t  status
);

  ced_pkg::entry_t                 mem_r [ced_pkg::QDEPTH];
  logic [ced_pkg::QPTR_W-1:0]      wr_ptr_r, rd_ptr_r;
  logic [ced_pkg::QCNT_W-1:0]      cnt_r, cnt_nxt;

  assign head         = mem_r[rd_ptr_r];
  assign status.full  = (cnt_r == ced_pkg::QCNT_W'(ced_pkg::QDEPTH));
  assign status.empty = (cnt_r == '0);

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= ced_pkg::QCNT_W'(ced_pkg::QDEPTH))
    else $error("queue count above depth");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !status.empty)
    else $error("pop from empty queue");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    status.full && !pop |-> !push)
    else $error("push into full queue");
`endif

endmodule

### hdl/ced_back.sv
// Back end: serializes each queue entry into one or two output words.
// Depends on ced_pkg.
module ced_back (
  input  logic                clk,
  input  logic                rst_n,
  input  ced_pkg::entry_t     head,
  input  ced_pkg::q_status_t  status,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output ced_pkg::out_word_t  out_data
);

  logic sel_r, sel_nxt;   // set while the second word of an entry is shown
  logic take;

  assign out_valid = !status.empty;
  assign out_data  = sel_r ? head.r1 : head.r0;
  assign take      = out_valid && out_ready;

  always_comb begin
    sel_nxt = sel_r;
    pop     = 1'b0;
    if (take) begin
      if (head.two && !sel_r) begin
        sel_nxt = 1'b1;
      end else begin
        sel_nxt = 1'b0;
        pop     = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r <= 1'b0;
    end else begin
      sel_r <= sel_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_pop_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> out_data.last)
    else $error("entry popped before its last word");

  a_sel_needs_two: assert property (@(posedge clk) disable iff (!rst_n)
    sel_r |-> (out_valid && head.two))
    else $error("second word selected for a single-word entry");

  a_first_then_second: assert property (@(posedge clk) disable iff (!rst_n)
    take && !pop |=> sel_r)
    else $error("second word of entry skipped");
`endif

endmodule

### hdl/c_literal_escape_decoder_core.sv
// C literal escape decoder, top level: front end, result queue, back end.
// Depends on ced_pkg, ced_front, ced_queue, ced_back.
//
// Input channel (in_valid/in_ready/in_data): one word per source character.
//   mode 0 opens a literal with symbol as delimiter, mode 1 feeds a character.
// Output channel (out_valid/out_ready/out_data): decoded bytes and end words;
//   last marks the final output word caused by one input word.
// Results are registered in the queue before they reach the output.
// Throughput: one input word per clock unless the queue is full. The front
//   end updates all literal state in the accept cycle, so consecutive
//   characters never wait on each other. A character yielding two words (an
//   octal run cut short) is sent as two words; the four-entry queue absorbs it.
// in_ready drops only when the queue is full. Words that yield no output
//   (opens, backslashes, octal digits mid-run) are taken even while the
//   receiver stalls, as long as the queue has room.
// When the receiver stalls, out_data holds and queued words wait in order.
// Reset (rst_n low, synchronous) closes any open literal and empties the
//   queue; no clearing pass is needed.
module c_literal_escape_decoder_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ced_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ced_pkg::out_word_t out_data
);

  logic               acc;
  logic               push;
  logic               pop;
  ced_pkg::entry_t    push_entry;
  ced_pkg::entry_t    head;
  ced_pkg::q_status_t status;

  assign in_ready = !status.full;
  assign acc      = in_valid && in_ready;

  ced_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (acc),
    .in_word    (in_data),
    .push       (push),
    .push_entry (push_entry)
  );

  ced_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .status     (status)
  );

  ced_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .status    (status),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
